FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NAE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define NAE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/nae_pkg.sv
// ----------------------------------------------------------------------------
// nae_pkg
// Shared types and constants of the accumulator evaluator.
// ----------------------------------------------------------------------------
package nae_pkg;

  // Lanes held in one memory word.
  localparam int LANES      = 16;
  localparam int LANE_BITS  = 4;
  localparam int DATA_W     = 16;

  // Default network shape.
  localparam int HIDDEN_UNITS_DEF = 256;
  localparam int PIECE_KINDS_DEF  = 6;
  localparam int BOARD_SQUARES    = 64;

  // Square mirror for the black view, and the output scaling.
  localparam logic [5:0] MIRROR_MASK = 6'd56;
  localparam int SCALE_SHIFT = 6;
  localparam int SCORE_W     = 25;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_LOAD_FW   = 3'd0,
    REQ_LOAD_BIAS = 3'd1,
    REQ_LOAD_OW   = 3'd2,
    REQ_BEGIN     = 3'd3,
    REQ_PIECE     = 3'd4,
    REQ_EVAL      = 3'd5
  } req_t;

  // Register indexes.
  localparam logic REG_OUTPUT_BIAS = 1'b0;
  localparam logic REG_CLIP_MAX    = 1'b1;

  // Control from the sequencer to the dot-product unit.
  typedef struct packed {
    logic start;
    logic vld;
    logic last;
  } dot_ctl_t;

endpackage

FILE: rtl/nae_ram.sv
// ----------------------------------------------------------------------------
// nae_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nae_dot.sv
// ----------------------------------------------------------------------------
// nae_dot
// Clipped-ReLU dot-product unit: clamps a word of hidden values, multiplies
// by the output weights, sums over words and scales the final result.
// ----------------------------------------------------------------------------
module nae_dot import nae_pkg::*; #(
  parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dot_ctl_t                  ctl,
  input  logic [LANES*DATA_W-1:0]   acc_word,
  input  logic [LANES*DATA_W-1:0]   ow_word,
  input  logic signed [DATA_W-1:0]  output_bias,
  input  logic [6:0]                clip_max,
  output logic                      done,
  output logic signed [SCORE_W-1:0] score
);

  localparam int WORDS  = (HIDDEN_UNITS + LANES - 1) / LANES;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PROD_W = 24;
  localparam int GRP_W  = PROD_W + 2;
  localparam int ACC_W  = PROD_W + LANE_BITS + WAW + 2;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SCORE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd1 <<< (SCORE_W - 1));
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'((1 << SCALE_SHIFT) - 1);

  logic [WAW-1:0]            wc;
  logic signed [PROD_W-1:0]  prod [LANES];
  logic signed [PROD_W-1:0]  prod_q [LANES];
  logic signed [GRP_W-1:0]   grp_q [4];
  logic signed [GRP_W+1:0]   grp_sum;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   adj;
  logic signed [ACC_W-1:0]   scaled;
  logic                      vld1, last1, vld2, last2, fin;

  // Clamp each lane and multiply by its output weight; padding lanes give zero.
  always_comb begin
    logic signed [DATA_W-1:0] h;
    logic [6:0]               c;
    for (int l = 0; l < LANES; l++) begin
      h = acc_word[l*DATA_W +: DATA_W];
      if (h[DATA_W-1]) begin
        c = 7'd0;
      end else if (h > $signed({9'd0, clip_max})) begin
        c = clip_max;
      end else begin
        c = h[6:0];
      end
      if (32'(wc) * LANES + l >= HIDDEN_UNITS) begin
        c = 7'd0;
      end
      prod[l] = PROD_W'($signed({1'b0, c}) * $signed(ow_word[l*DATA_W +: DATA_W]));
    end
  end

  // Final group sum and truncating scale.
  always_comb begin
    grp_sum = (GRP_W+2)'(grp_q[0]) + (GRP_W+2)'(grp_q[1])
            + (GRP_W+2)'(grp_q[2]) + (GRP_W+2)'(grp_q[3]);
    adj     = acc + (acc[ACC_W-1] ? ROUND : '0);
    scaled  = adj >>> SCALE_SHIFT;
  end

  // Product, group-sum, accumulate and scale stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      last1 <= 1'b0;
      vld2 <= 1'b0;
      last2 <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      wc   <= '0;
    end else begin
      vld1  <= ctl.vld;
      last1 <= ctl.vld && ctl.last;
      vld2  <= vld1;
      last2 <= last1;
      fin   <= vld2 && last2;
      done  <= fin;
      if (ctl.start) begin
        wc <= '0;
      end else if (ctl.vld) begin
        wc <= wc + 1'b1;
      end
    end
    prod_q <= prod;
    for (int g = 0; g < 4; g++) begin
      grp_q[g] <= GRP_W'(prod_q[4*g]) + GRP_W'(prod_q[4*g+1])
                + GRP_W'(prod_q[4*g+2]) + GRP_W'(prod_q[4*g+3]);
    end
    if (ctl.start) begin
      acc <= ACC_W'(output_bias);
    end else if (vld2) begin
      acc <= acc + ACC_W'(grp_sum);
    end
    if (fin) begin
      if (scaled > SAT_MAX) begin
        score <= SAT_MAX[SCORE_W-1:0];
      end else if (scaled < SAT_MIN) begin
        score <= SAT_MIN[SCORE_W-1:0];
      end else begin
        score <= scaled[SCORE_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/nnue_accumulator_evaluator_top.sv
// ----------------------------------------------------------------------------
// nnue_accumulator_evaluator_top
// Single-layer evaluation network with two perspective accumulators.
// ----------------------------------------------------------------------------
// All weights and both accumulators live in synchronous RAMs of 16 lanes per
// word, so the cost of an item is set by how many words it sweeps
// (WORDS = HIDDEN_UNITS/16 rounded up, 16 by default). A weight or bias load
// is a read-modify-write of one word. A begin request sweeps the words once
// and a piece request twice, since the one feature-weight RAM port serves
// the white view and then the black view. An evaluate request sweeps the
// words through the dot-product pipeline before its score is offered.
// Accumulator words carry valid bits cleared by reset, so no clearing pass is
// needed after reset.
module nnue_accumulator_evaluator_top import nae_pkg::*; #(
  parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF,
  parameter int PIECE_KINDS  = PIECE_KINDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                req_type,
  input  logic [9:0]                feature_index,
  input  logic [7:0]                hidden_index,
  input  logic signed [15:0]        weight_value,
  input  logic [2:0]                piece_type,
  input  logic                      piece_color,
  input  logic [5:0]                square,
  input  logic                      perspective,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] score,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

`include "assert_macros.svh"

  localparam int WORDS  = (HIDDEN_UNITS + LANES - 1) / LANES;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FROWS  = 2 * PIECE_KINDS * BOARD_SQUARES;
  localparam int FDEPTH = FROWS * WORDS;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int WORD_W = LANES * DATA_W;
  localparam int IXW    = (WAW + LANE_BITS > 8) ? WAW + LANE_BITS : 8;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_BEGIN, S_PIECE, S_EVAL, S_DRAIN, S_EVAL_WAIT, S_DELIVER
  } state_t;

  state_t                     state;
  req_t                       lop;
  logic [WAW-1:0]             lword;
  logic [LANE_BITS-1:0]       llane;
  logic [DATA_W-1:0]          lwval;
  logic [FAW-1:0]             lfaddr;
  logic [FAW-1:0]             base_w, base_b;
  logic                       lview;
  logic                       pv;
  logic [WAW-1:0]             cnt;
  logic                       cnt_last;

  logic                       p_vld, p_view, p_last;
  req_t                       p_kind;
  logic [WAW-1:0]             p_addr;
  logic [1:0]                 p_avld;
  logic [WORDS-1:0]           vbits [2];

  logic signed [DATA_W-1:0]   output_bias;
  logic [6:0]                 clip_max;

  logic [IXW-1:0]             hx;
  logic                       hidx_ok, fidx_ok, ptype_ok, accept, issuing;
  logic [31:0]                wrow, brow;

  logic                       fw_we, bias_we, ow_we;
  logic [FAW-1:0]             fw_raddr;
  logic [WAW-1:0]             wt_raddr;
  logic [WORD_W-1:0]          fw_rdata, bias_rdata, ow_rdata;
  logic [WORD_W-1:0]          fw_wdata, bias_wdata, ow_wdata;
  logic [1:0]                 acc_we;
  logic [WORD_W-1:0]          acc_wdata [2];
  logic [WORD_W-1:0]          acc_rdata [2];
  logic [WORD_W-1:0]          acc_eff [2];

  dot_ctl_t                   dctl;
  logic                       dot_done;
  logic signed [SCORE_W-1:0]  dot_score;

  // Replace one lane of a word.
  function automatic logic [WORD_W-1:0] merge_lane(input logic [WORD_W-1:0] w,
                                                   input logic [LANE_BITS-1:0] lane,
                                                   input logic [DATA_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = w;
    r[lane*DATA_W +: DATA_W] = v;
    return r;
  endfunction

  // Request decode and range checks.
  assign hx       = IXW'(hidden_index);
  assign hidx_ok  = 32'(hidden_index) < HIDDEN_UNITS;
  assign fidx_ok  = 32'(feature_index) < FROWS;
  assign ptype_ok = 32'(piece_type) < PIECE_KINDS;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign issuing  = (state == S_BEGIN) || (state == S_PIECE) || (state == S_EVAL);
  assign cnt_last = (cnt == WAW'(WORDS - 1));
  assign wrow = (32'(piece_color) * PIECE_KINDS + 32'(piece_type)) * BOARD_SQUARES
              + 32'(square);
  assign brow = (32'(!piece_color) * PIECE_KINDS + 32'(piece_type)) * BOARD_SQUARES
              + 32'(square ^ MIRROR_MASK);

  // Memory addressing and write data.
  always_comb begin
    fw_raddr = (state == S_LD_RD) ? lfaddr : ((pv ? base_b : base_w) + FAW'(cnt));
    wt_raddr = (state == S_LD_RD) ? lword : cnt;
    fw_we    = (state == S_LD_WR) && (lop == REQ_LOAD_FW);
    bias_we  = (state == S_LD_WR) && (lop == REQ_LOAD_BIAS);
    ow_we    = (state == S_LD_WR) && (lop == REQ_LOAD_OW);
    fw_wdata   = merge_lane(fw_rdata, llane, lwval);
    bias_wdata = merge_lane(bias_rdata, llane, lwval);
    ow_wdata   = merge_lane(ow_rdata, llane, lwval);
    for (int v = 0; v < 2; v++) begin
      acc_eff[v] = p_avld[v] ? acc_rdata[v] : '0;
    end
    acc_we = 2'b00;
    for (int v = 0; v < 2; v++) begin
      acc_wdata[v] = bias_rdata;
      if (p_kind == REQ_PIECE) begin
        for (int l = 0; l < LANES; l++) begin
          acc_wdata[v][l*DATA_W +: DATA_W] = acc_eff[v][l*DATA_W +: DATA_W]
                                           + fw_rdata[l*DATA_W +: DATA_W];
        end
      end
    end
    if (p_vld && (p_kind == REQ_BEGIN)) begin
      acc_we = 2'b11;
    end else if (p_vld && (p_kind == REQ_PIECE)) begin
      acc_we[p_view] = 1'b1;
    end
  end

  // Sequencer, read pipeline and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      pv        <= 1'b0;
      vbits[0]  <= '0;
      vbits[1]  <= '0;
    end else begin
      p_vld <= issuing;
      for (int v = 0; v < 2; v++) begin
        if (acc_we[v]) begin
          vbits[v][p_addr] <= 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          pv  <= 1'b0;
          if (accept) begin
            case (req_type) inside
              REQ_LOAD_FW: begin
                if (fidx_ok && hidx_ok) begin
                  state <= S_LD_RD;
                end
              end
              REQ_LOAD_BIAS, REQ_LOAD_OW: begin
                if (hidx_ok) begin
                  state <= S_LD_RD;
                end
              end
              REQ_BEGIN: state <= S_BEGIN;
              REQ_PIECE: begin
                if (ptype_ok) begin
                  state <= S_PIECE;
                end
              end
              REQ_EVAL: state <= S_EVAL;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_IDLE;
        S_BEGIN, S_EVAL: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= (state == S_EVAL) ? S_EVAL_WAIT : S_DRAIN;
          end
        end
        S_PIECE: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            cnt <= '0;
            pv  <= 1'b1;
            if (pv) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: state <= S_IDLE;
        S_EVAL_WAIT: begin
          if (dot_done) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    // Request fields held for the whole operation.
    if (accept) begin
      lop    <= req_t'(req_type);
      lword  <= hx[WAW+LANE_BITS-1:LANE_BITS];
      llane  <= hidden_index[LANE_BITS-1:0];
      lwval  <= weight_value;
      lfaddr <= FAW'(32'(feature_index) * WORDS + 32'(hx[WAW+LANE_BITS-1:LANE_BITS]));
      base_w <= FAW'(wrow * WORDS);
      base_b <= FAW'(brow * WORDS);
      lview  <= perspective;
    end
    // Read pipeline bookkeeping, registered to arrive in the cycle after the address.
    p_kind    <= lop;
    p_addr    <= cnt;
    p_last    <= cnt_last;
    p_view    <= (state == S_EVAL) ? lview : pv;
    p_avld[0] <= vbits[0][cnt];
    p_avld[1] <= vbits[1][cnt];
    if ((state == S_DELIVER) && (!out_valid || out_ready)) begin
      score <= dot_score;
    end
  end

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      output_bias <= '0;
      clip_max    <= 7'd127;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_OUTPUT_BIAS: output_bias <= pwdata[15:0];
        REG_CLIP_MAX:    clip_max    <= pwdata[6:0];
        default:         clip_max    <= clip_max;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OUTPUT_BIAS: prdata = 32'(output_bias);
      REG_CLIP_MAX:    prdata = {25'd0, clip_max};
      default:         prdata = '0;
    endcase
  end

  // Memories.
  nae_ram #(.WIDTH(WORD_W), .DEPTH(FDEPTH)) u_fw_ram (
    .clk(clk), .we(fw_we), .waddr(lfaddr), .wdata(fw_wdata),
    .raddr(fw_raddr), .rdata(fw_rdata)
  );
  nae_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_bias_ram (
    .clk(clk), .we(bias_we), .waddr(lword), .wdata(bias_wdata),
    .raddr(wt_raddr), .rdata(bias_rdata)
  );
  nae_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ow_ram (
    .clk(clk), .we(ow_we), .waddr(lword), .wdata(ow_wdata),
    .raddr(wt_raddr), .rdata(ow_rdata)
  );
  for (genvar v = 0; v < 2; v++) begin : g_acc
    nae_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_acc_ram (
      .clk(clk), .we(acc_we[v]), .waddr(p_addr), .wdata(acc_wdata[v]),
      .raddr(cnt), .rdata(acc_rdata[v])
    );
  end

  // Dot-product unit.
  assign dctl.start = accept && (req_type == REQ_EVAL);
  assign dctl.vld   = p_vld && (p_kind == REQ_EVAL);
  assign dctl.last  = p_last;

  nae_dot #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_dot (
    .clk(clk), .rst(rst), .ctl(dctl),
    .acc_word(acc_eff[p_view]), .ow_word(ow_rdata),
    .output_bias(output_bias), .clip_max(clip_max),
    .done(dot_done), .score(dot_score)
  );

  // No accumulator write may still be pending when a new request is taken.
  `NAE_ASSERT_IMP(a_idle_no_pending, clk, rst, in_ready, !p_vld)
  // A finished dot product only ever arrives while its evaluate waits.
  `NAE_ASSERT_IMP(a_done_in_wait, clk, rst, dot_done, state == S_EVAL_WAIT)
  // A score is offered only from the delivery step.
  `NAE_ASSERT_NXT(a_deliver_sets_out, clk, rst,
                  (state == S_DELIVER) && (!out_valid || out_ready),
                  out_valid && (state == S_IDLE))

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Accumulator evaluator testbench
// Loads the biases, the output weights and a set of feature rows, then sends
// directed and random requests under changing register settings and idle
// patterns. Every score is checked against a behavioral model of the network.
// ----------------------------------------------------------------------------
module testbench import nae_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HU         = HIDDEN_UNITS_DEF;
  localparam int KINDS      = PIECE_KINDS_DEF;
  localparam int ROWS       = 2 * KINDS * BOARD_SQUARES;
  localparam int DRAIN_GAP  = 60;
  localparam int STALL_MAX  = 20000;
  localparam int RAND_ITEMS = 1150;

  // Codes that the block must ignore.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]   req;
    logic [9:0]   fidx;
    logic [7:0]   hidx;
    logic [15:0]  wval;
    logic [2:0]   ptype;
    logic         color;
    logic [5:0]   sq;
    logic         persp;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [9:0] feature_index = '0;
  logic [7:0] hidden_index = '0;
  logic signed [15:0] weight_value = '0;
  logic [2:0] piece_type = '0;
  logic piece_color = 1'b0;
  logic [5:0] square = '0;
  logic perspective = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SCORE_W-1:0] score;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nnue_accumulator_evaluator_top dut (.*);

  always #5 clk = ~clk;

  // Model state of the network.
  logic [15:0] feat_w [0:ROWS*HU-1];
  logic [15:0] hid_bias [0:HU-1];
  logic [15:0] out_w [0:HU-1];
  logic [15:0] accum [0:1][0:HU-1];
  logic signed [15:0] bias_reg = 16'sd0;
  logic [6:0] clip_reg = 7'd127;
  bit row_loaded [0:ROWS-1];

  request_t pending_reqs[$];
  logic [SCORE_W-1:0] expected_scores[$];
  request_t cur_req;
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int accepted_reqs = 0;
  int checked_scores = 0;
  int stall_count = 0;

  // Square and piece pairs whose four feature rows are fully loaded.
  logic [2:0] pair_kind [0:2] = '{3'd0, 3'd5, 3'd3};
  logic [5:0] pair_sq   [0:2] = '{6'd0, 6'd63, 6'd27};

  function automatic int row_of(logic c, logic [2:0] t, logic [5:0] s);
    return (int'(c) * KINDS + int'(t)) * BOARD_SQUARES + int'(s);
  endfunction

  // Score of one view: clipped ReLU, dot product, bias, divide by 64, saturate.
  function automatic logic [SCORE_W-1:0] view_score(logic v);
    longint acc_sum;
    int h;
    acc_sum = longint'(bias_reg);
    for (int j = 0; j < HU; j++) begin
      h = int'($signed(accum[v][j]));
      if (h < 0) h = 0;
      if (h > int'(clip_reg)) h = int'(clip_reg);
      acc_sum += longint'(h) * longint'($signed(out_w[j]));
    end
    acc_sum = acc_sum / 64;
    if (acc_sum > 64'sd16777215) acc_sum = 64'sd16777215;
    if (acc_sum < -64'sd16777216) acc_sum = -64'sd16777216;
    return acc_sum[SCORE_W-1:0];
  endfunction

  // Applies one accepted request to the model and queues any score.
  task automatic apply_request(request_t r);
    int wrow;
    int brow;
    case (r.req)
      REQ_LOAD_FW: if (r.fidx < ROWS) feat_w[int'(r.fidx) * HU + int'(r.hidx)] = r.wval;
      REQ_LOAD_BIAS: hid_bias[r.hidx] = r.wval;
      REQ_LOAD_OW: out_w[r.hidx] = r.wval;
      REQ_BEGIN: begin
        for (int j = 0; j < HU; j++) begin
          accum[0][j] = hid_bias[j];
          accum[1][j] = hid_bias[j];
        end
      end
      REQ_PIECE: begin
        if (r.ptype < KINDS) begin
          wrow = row_of(r.color, r.ptype, r.sq);
          brow = row_of(~r.color, r.ptype, r.sq ^ MIRROR_MASK);
          for (int j = 0; j < HU; j++) begin
            accum[0][j] = accum[0][j] + feat_w[wrow * HU + j];
            accum[1][j] = accum[1][j] + feat_w[brow * HU + j];
          end
        end
      end
      REQ_EVAL: expected_scores.push_back(view_score(r.persp));
      default: ;
    endcase
  endtask

  // Request with every field random; callers set the fields that matter.
  function automatic request_t noise_request(logic [2:0] code);
    request_t r;
    r = request_t'(48'({$urandom, $urandom}));
    r.req = code;
    return r;
  endfunction

  function automatic request_t piece_request(logic [2:0] t, logic [5:0] s, logic c);
    request_t r;
    r = noise_request(REQ_PIECE);
    r.ptype = t;
    r.sq = s;
    r.color = c;
    return r;
  endfunction

  function automatic request_t eval_request(logic v);
    request_t r;
    r = noise_request(REQ_EVAL);
    r.persp = v;
    return r;
  endfunction

  function automatic request_t load_request(logic [2:0] code, logic [9:0] f, logic [7:0] h,
                                            logic [15:0] w);
    request_t r;
    r = noise_request(code);
    r.fidx = f;
    r.hidx = h;
    r.wval = w;
    return r;
  endfunction

  // Random request that never reads an unwritten weight.
  function automatic request_t random_request();
    int pick;
    int p;
    int rw;
    pick = $urandom_range(99);
    p = $urandom_range(2);
    if (pick < 42) begin
      return piece_request(pair_kind[p], pair_sq[p] ^ ($urandom_range(1) ? MIRROR_MASK : 6'd0),
                           1'($urandom));
    end else if (pick < 48) begin
      return piece_request(3'($urandom_range(KINDS, 7)), 6'($urandom), 1'($urandom));
    end else if (pick < 64) begin
      return eval_request(1'($urandom));
    end else if (pick < 72) begin
      return noise_request(REQ_BEGIN);
    end else if (pick < 84) begin
      // Feature load: mostly into a loaded row, sometimes past the table.
      if ($urandom_range(3) == 0) rw = $urandom_range(ROWS, 1023);
      else do rw = $urandom_range(ROWS - 1); while (!row_loaded[rw]);
      return load_request(REQ_LOAD_FW, 10'(rw), 8'($urandom), 16'($urandom));
    end else if (pick < 90) begin
      return load_request(REQ_LOAD_BIAS, 10'($urandom), 8'($urandom), 16'($urandom));
    end else if (pick < 96) begin
      return load_request(REQ_LOAD_OW, 10'($urandom), 8'($urandom), 16'($urandom));
    end
    return noise_request($urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(cur_req);
        accepted_reqs++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_req.req;
          feature_index <= cur_req.fidx;
          hidden_index <= cur_req.hidx;
          weight_value <= cur_req.wval;
          piece_type <= cur_req.ptype;
          piece_color <= cur_req.color;
          square <= cur_req.sq;
          perspective <= cur_req.persp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Score monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected score %0d", score);
        end else begin
          if (score !== expected_scores[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("score expected %0d got %0d",
                       $signed(expected_scores[0]), score);
          end
          void'(expected_scores.pop_front());
          checked_scores++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any accepted request or score.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_MAX) begin
      $display("nnue_accumulator_evaluator_top: mismatch");
      $finish;
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {1'b0, idx, 1'b0} << 1;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_OUTPUT_BIAS) bias_reg = val[15:0];
    else clip_reg = val[6:0];
  endtask

  // Waits until all requests are taken and all scores have arrived.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  logic signed [15:0] phase_bias [0:5] = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd500,
                                           -16'sd1, 16'sd9000};
  logic [6:0] phase_clip [0:5] = '{7'd127, 7'd1, 7'd127, 7'd0, 7'd64, 7'd33};

  initial begin
    int rw;
    // Both accumulators read as zero until the first begin or piece request.
    for (int v = 0; v < 2; v++)
      for (int j = 0; j < HU; j++) accum[v][j] = 16'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 23 : (p < 4) ? 75 : 0;
      recv_idle = (p < 2) ? 75 : (p < 4) ? 23 : 0;
      reg_write(REG_OUTPUT_BIAS, 32'(phase_bias[p]));
      reg_write(REG_CLIP_MAX, (p == 4) ? 32'($urandom_range(127)) : 32'(phase_clip[p]));
      if (p == 0) begin
        // Fill the biases, the output weights and the rows of the piece pairs.
        for (int j = 0; j < HU; j++) begin
          pending_reqs.push_back(load_request(REQ_LOAD_OW, 10'($urandom), 8'(j),
                                              16'($urandom)));
          pending_reqs.push_back(load_request(REQ_LOAD_BIAS, 10'($urandom), 8'(j),
                                              16'($urandom)));
        end
        for (int k = 0; k < 3; k++)
          for (int c = 0; c < 2; c++)
            for (int m = 0; m < 2; m++) begin
              rw = row_of(c[0], pair_kind[k], pair_sq[k] ^ (m[0] ? MIRROR_MASK : 6'd0));
              row_loaded[rw] = 1'b1;
              for (int j = 0; j < HU; j++)
                pending_reqs.push_back(load_request(REQ_LOAD_FW, 10'(rw), 8'(j),
                                                    16'($urandom)));
            end
        // Directed part: accumulators still zero, then the special cases.
        pending_reqs.push_back(eval_request(1'b0));
        pending_reqs.push_back(eval_request(1'b1));
        pending_reqs.push_back(piece_request(3'd5, 6'd63, 1'b1));
        pending_reqs.push_back(eval_request(1'b1));
        pending_reqs.push_back(noise_request(REQ_BEGIN));
        pending_reqs.push_back(eval_request(1'b0));
        pending_reqs.push_back(piece_request(3'd0, 6'd0, 1'b0));
        pending_reqs.push_back(piece_request(3'd0, 6'd56, 1'b1));
        pending_reqs.push_back(piece_request(3'd3, 6'd27, 1'b0));
        pending_reqs.push_back(piece_request(3'd6, 6'd0, 1'b0));
        pending_reqs.push_back(piece_request(3'd7, 6'd63, 1'b1));
        pending_reqs.push_back(noise_request(REQ_SPARE_LO));
        pending_reqs.push_back(noise_request(REQ_SPARE_HI));
        pending_reqs.push_back(load_request(REQ_LOAD_FW, 10'd1023, 8'd255, 16'h7fff));
        pending_reqs.push_back(load_request(REQ_LOAD_FW, 10'd768, 8'd0, 16'h8000));
        pending_reqs.push_back(load_request(REQ_LOAD_OW, 10'd0, 8'd0, 16'h7fff));
        pending_reqs.push_back(load_request(REQ_LOAD_OW, 10'd0, 8'd255, 16'h8000));
        pending_reqs.push_back(eval_request(1'b0));
        pending_reqs.push_back(eval_request(1'b1));
      end
      for (int i = 0; i < RAND_ITEMS / 6; i++) pending_reqs.push_back(random_request());
      drain();
    end
    $display("Covered %0d requests and %0d checked scores over six register settings.",
             accepted_reqs, checked_scores);
    if (mismatches == 0) begin
      $display("nnue_accumulator_evaluator_top: match");
    end else begin
      $display("nnue_accumulator_evaluator_top: mismatch");
    end
    $finish;
  end

endmodule
